FILE: sv/orl_pkg.sv
// shared types and constants of the ordered record list
// no dependencies; used by every other file of the block

package orl_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMD_W = 3;
  localparam int POS_W = 5;
  localparam int KEY_W = 32;
  localparam int AGE_W = 8;
  localparam int CAT_W = 8;
  localparam int ST_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CmdInsert = 3'd0,
    CmdDelete = 3'd1,
    CmdFind   = 3'd2,
    CmdModify = 3'd3,
    CmdCount  = 3'd4
  } orl_cmd_e;

  typedef enum logic [ST_W-1:0] {
    StOk       = 3'd0,
    StBadPos   = 3'd1,
    StDup      = 3'd2,
    StFull     = 3'd3,
    StNotFound = 3'd4
  } orl_status_e;

  typedef enum logic {
    StateIdle,
    StateExec
  } orl_state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic             sex;
    logic [AGE_W-1:0] age;
    logic [CAT_W-1:0] category;
  } orl_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] hit_position;
    logic             found_sex;
    logic [AGE_W-1:0] found_age;
    logic [CAT_W-1:0] found_category;
    logic [POS_W-1:0] match_count;
    logic [POS_W-1:0] entry_count;
  } orl_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             sex;
    logic [AGE_W-1:0] age;
    logic [CAT_W-1:0] category;
  } orl_rec_t;

  typedef struct packed {
    logic load;
    logic exec;
  } orl_ctrl_t;

endpackage

FILE: sv/orl_req_if.sv
// command channel of the ordered record list
// depends on orl_pkg

interface orl_req_if;
  logic              valid;
  logic              ready;
  orl_pkg::orl_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/orl_rsp_if.sv
// result channel of the ordered record list
// depends on orl_pkg

interface orl_rsp_if;
  logic              valid;
  logic              ready;
  orl_pkg::orl_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/orl_ctrl.sv
// controller of the ordered record list: sequences accept and execute
// depends on orl_pkg

module orl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output orl_pkg::orl_ctrl_t  ctrl_o
);

  orl_pkg::orl_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= orl_pkg::StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    out_valid_d = out_valid_q && !rsp_ready_i;
    unique case (state_q)
      orl_pkg::StateIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = orl_pkg::StateExec;
        end
      end
      orl_pkg::StateExec: begin
        if (!out_valid_q || rsp_ready_i) begin
          ctrl_o.exec = 1'b1;
          out_valid_d = 1'b1;
          state_d     = orl_pkg::StateIdle;
        end
      end
      default: state_d = orl_pkg::StateIdle;
    endcase
  end

  assign rsp_valid_o = out_valid_q;

endmodule

FILE: sv/orl_dp.sv
// datapath of the ordered record list: entry cells, match vectors, result register
// depends on orl_pkg

module orl_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  orl_pkg::orl_ctrl_t ctrl_i,
  input  orl_pkg::orl_req_t  req_i,
  output orl_pkg::orl_rsp_t  rsp_o
);

  orl_pkg::orl_rec_t                  ents_q [orl_pkg::DEPTH];
  orl_pkg::orl_rec_t                  ents_d [orl_pkg::DEPTH];
  orl_pkg::orl_rec_t                  prv    [orl_pkg::DEPTH];
  orl_pkg::orl_rec_t                  nxt    [orl_pkg::DEPTH];
  logic [orl_pkg::CNT_W-1:0]          fill_q, fill_d;
  orl_pkg::orl_req_t                  req_q;
  orl_pkg::orl_rsp_t                  rsp_q, rsp_d;
  logic [orl_pkg::DEPTH-1:0]          hit_q, hit_d, cat_q, cat_d;
  logic [orl_pkg::IDX_W-1:0]          hit_idx, ins_at;
  logic                               hit_any, pos_ok;
  orl_pkg::orl_rec_t                  hit_rec, new_rec;
  logic [orl_pkg::POS_W-1:0]          hit_pos;

  // per-cell compares against the incoming command
  always_comb begin
    for (int i = 0; i < orl_pkg::DEPTH; i++) begin
      hit_d[i] = (orl_pkg::CNT_W'(i) < fill_q) && (ents_q[i].key == req_i.key);
      cat_d[i] = (orl_pkg::CNT_W'(i) < fill_q) && (ents_q[i].category == req_i.category);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.exec) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
      hit_q <= hit_d;
      cat_q <= cat_d;
    end
    if (ctrl_i.exec) begin
      rsp_q <= rsp_d;
      for (int i = 0; i < orl_pkg::DEPTH; i++) begin
        ents_q[i] <= ents_d[i];
      end
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = orl_pkg::DEPTH - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = orl_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    prv[0]                  = ents_q[0];
    nxt[orl_pkg::DEPTH-1]   = ents_q[orl_pkg::DEPTH-1];
    for (int i = 1; i < orl_pkg::DEPTH; i++) begin
      prv[i]   = ents_q[i-1];
      nxt[i-1] = ents_q[i];
    end
  end

  assign hit_any = |hit_q;
  assign hit_rec = ents_q[hit_idx];
  assign hit_pos = orl_pkg::POS_W'(hit_idx) + orl_pkg::POS_W'(1);
  assign ins_at  = orl_pkg::IDX_W'(req_q.position - orl_pkg::POS_W'(1));
  assign pos_ok  = (req_q.position != '0) &&
                   ((orl_pkg::CNT_W + 1)'(req_q.position) <=
                    (orl_pkg::CNT_W + 1)'(fill_q) + (orl_pkg::CNT_W + 1)'(1));
  assign new_rec = '{key: req_q.key, sex: req_q.sex, age: req_q.age,
                     category: req_q.category};

  always_comb begin
    rsp_d  = '0;
    fill_d = fill_q;
    for (int i = 0; i < orl_pkg::DEPTH; i++) begin
      ents_d[i] = ents_q[i];
    end
    unique case (req_q.command)
      orl_pkg::CmdInsert: begin
        if (!pos_ok) begin
          rsp_d.status = orl_pkg::StBadPos;
        end else if (hit_any) begin
          rsp_d.status = orl_pkg::StDup;
        end else if (fill_q == orl_pkg::CNT_W'(orl_pkg::DEPTH)) begin
          rsp_d.status = orl_pkg::StFull;
        end else begin
          for (int i = 0; i < orl_pkg::DEPTH; i++) begin
            if (orl_pkg::IDX_W'(i) == ins_at) begin
              ents_d[i] = new_rec;
            end else if (orl_pkg::IDX_W'(i) > ins_at && orl_pkg::CNT_W'(i) <= fill_q) begin
              ents_d[i] = prv[i];
            end
          end
          fill_d               = fill_q + orl_pkg::CNT_W'(1);
          rsp_d.hit_position   = req_q.position;
          rsp_d.found_sex      = req_q.sex;
          rsp_d.found_age      = req_q.age;
          rsp_d.found_category = req_q.category;
        end
      end
      orl_pkg::CmdDelete, orl_pkg::CmdFind, orl_pkg::CmdModify: begin
        if (!hit_any) begin
          rsp_d.status = orl_pkg::StNotFound;
        end else begin
          rsp_d.hit_position   = hit_pos;
          rsp_d.found_sex      = hit_rec.sex;
          rsp_d.found_age      = hit_rec.age;
          rsp_d.found_category = hit_rec.category;
          if (req_q.command == orl_pkg::CmdDelete) begin
            for (int i = 0; i < orl_pkg::DEPTH; i++) begin
              if (orl_pkg::IDX_W'(i) >= hit_idx && orl_pkg::CNT_W'(i + 1) < fill_q) begin
                ents_d[i] = nxt[i];
              end
            end
            fill_d = fill_q - orl_pkg::CNT_W'(1);
          end else if (req_q.command == orl_pkg::CmdModify) begin
            for (int i = 0; i < orl_pkg::DEPTH; i++) begin
              if (hit_q[i]) begin
                ents_d[i].sex      = req_q.sex;
                ents_d[i].age      = req_q.age;
                ents_d[i].category = req_q.category;
              end
            end
            rsp_d.found_sex      = req_q.sex;
            rsp_d.found_age      = req_q.age;
            rsp_d.found_category = req_q.category;
          end
        end
      end
      orl_pkg::CmdCount: begin
        rsp_d.match_count = orl_pkg::POS_W'($countones(cat_q));
      end
      default: rsp_d.status = orl_pkg::StOk;
    endcase
    rsp_d.entry_count = orl_pkg::POS_W'(fill_d);
  end

  assign rsp_o = rsp_q;

endmodule

FILE: sv/ordered_record_list.sv
// Ordered record list: a positional list of up to 16 keyed records held in a
// row of register cells. In the transfer cycle of a command all cells compare
// their key and category against the command; in the execute step, once the
// output register is free, the cells insert, shift out, rewrite or count and
// the result is loaded into the output register. A new command is taken in the
// cycle after that, so only one command is in flight at a time; a result that
// is not taken holds the execute step until the register frees.
// top level; depends on orl_pkg, orl_req_if, orl_rsp_if, orl_ctrl and orl_dp

module ordered_record_list (
  input  logic       clk_i,
  input  logic       rst_ni,
  orl_req_if.sink    req_i,
  orl_rsp_if.source  rsp_o
);

  orl_pkg::orl_ctrl_t ctrl;

  orl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .ctrl_o      (ctrl)
  );

  orl_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i.data),
    .rsp_o  (rsp_o.data)
  );

  // one command in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("command taken while another is in execution");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.data.entry_count <= orl_pkg::POS_W'(orl_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_miss_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.status != orl_pkg::StOk) |->
    (rsp_o.data.hit_position == '0 && rsp_o.data.match_count == '0))
    else $error("failed command reports a position or a count");

endmodule

FILE: verif/orl_checker.sv
// result checker for the ordered record list: watches both channels, keeps its own copy
// of the list, predicts each result and compares it field by field
// depends on orl_pkg, orl_req_if and orl_rsp_if

module orl_checker (
  input  logic clk_i,
  input  logic rst_ni,
  orl_req_if   req_i,
  orl_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  orl_pkg::orl_rec_t records [orl_pkg::DEPTH];
  int                held;
  orl_pkg::orl_rsp_t expected_q [$];
  int                fails;
  int                checked;
  string             field_names [7] = '{"status", "hit_position", "found_sex", "found_age",
                                         "found_category", "match_count", "entry_count"};

  function automatic orl_pkg::orl_rsp_t with_record(orl_pkg::orl_rsp_t r, int at);
    r.hit_position   = orl_pkg::POS_W'(at + 1);
    r.found_sex      = records[at].sex;
    r.found_age      = records[at].age;
    r.found_category = records[at].category;
    return r;
  endfunction

  function automatic orl_pkg::orl_rsp_t execute_command(orl_pkg::orl_req_t c);
    orl_pkg::orl_rsp_t r;
    int hit;
    int at;
    int n;
    int i;
    r = '0;
    r.status = orl_pkg::StOk;
    hit = -1;
    n = 0;
    for (i = 0; i < held; i++) begin
      if (hit < 0 && records[i].key == c.key) begin
        hit = i;
      end
    end
    case (c.command)
      orl_pkg::CmdInsert: begin
        if (c.position < 1 || c.position > held + 1) begin
          r.status = orl_pkg::StBadPos;
        end else if (hit >= 0) begin
          r.status = orl_pkg::StDup;
        end else if (held >= orl_pkg::DEPTH) begin
          r.status = orl_pkg::StFull;
        end else begin
          at = int'(c.position) - 1;
          for (i = held; i > at; i--) begin
            records[i] = records[i-1];
          end
          records[at] = '{key: c.key, sex: c.sex, age: c.age, category: c.category};
          held++;
          r = with_record(r, at);
        end
      end
      orl_pkg::CmdDelete: begin
        if (hit < 0) begin
          r.status = orl_pkg::StNotFound;
        end else begin
          r = with_record(r, hit);
          for (i = hit; i < held - 1; i++) begin
            records[i] = records[i+1];
          end
          held--;
        end
      end
      orl_pkg::CmdFind: begin
        if (hit < 0) begin
          r.status = orl_pkg::StNotFound;
        end else begin
          r = with_record(r, hit);
        end
      end
      orl_pkg::CmdModify: begin
        if (hit < 0) begin
          r.status = orl_pkg::StNotFound;
        end else begin
          records[hit].sex      = c.sex;
          records[hit].age      = c.age;
          records[hit].category = c.category;
          r = with_record(r, hit);
        end
      end
      orl_pkg::CmdCount: begin
        for (i = 0; i < held; i++) begin
          if (records[i].category == c.category) begin
            n++;
          end
        end
        r.match_count = orl_pkg::POS_W'(n);
      end
      default: begin
      end
    endcase
    r.entry_count = orl_pkg::POS_W'(held);
    return r;
  endfunction

  task automatic compare_result(orl_pkg::orl_rsp_t want, orl_pkg::orl_rsp_t got);
    logic [31:0] want_f [7];
    logic [31:0] got_f [7];
    want_f = '{32'(want.status), 32'(want.hit_position), 32'(want.found_sex),
               32'(want.found_age), 32'(want.found_category), 32'(want.match_count),
               32'(want.entry_count)};
    got_f  = '{32'(got.status), 32'(got.hit_position), 32'(got.found_sex),
               32'(got.found_age), 32'(got.found_category), 32'(got.match_count),
               32'(got.entry_count)};
    if (got !== want) begin
      fails++;
      foreach (want_f[i]) begin
        if (got_f[i] !== want_f[i]) begin
          $display("%0t: result %0d %s expected %0d actual %0d",
                   $time, checked, field_names[i], want_f[i], got_f[i]);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      fails = 0;
      checked = 0;
      expected_q.delete();
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: result %0d expected none actual %p", $time, checked, rsp_i.data);
        end else begin
          compare_result(expected_q.pop_front(), rsp_i.data);
        end
        checked++;
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(execute_command(req_i.data));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_q.size();
    checked_o    <= checked;
  end

endmodule

FILE: verif/tb.sv
// testbench top for the ordered record list: clock, reset, command stimulus with random
// gaps and result back-pressure, a stall watchdog and the verdict
// depends on orl_pkg, orl_req_if, orl_rsp_if, ordered_record_list and orl_checker

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [orl_pkg::CMD_W-1:0] CmdUnusedLo  = 3'd5;
  localparam logic [orl_pkg::CMD_W-1:0] CmdUnusedMid = 3'd6;
  localparam logic [orl_pkg::CMD_W-1:0] CmdUnusedHi  = 3'd7;
  localparam int RANDOM_CMDS  = 2000;
  localparam int KEY_POOL     = 24;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i;
  logic rst_ni;
  logic calm;
  int   fail_count;
  int   pending;
  int   checked;
  int   stall_cycles = 0;
  int   sent [8] = '{default: 0};
  logic [orl_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  orl_req_if req_if ();
  orl_rsp_if rsp_if ();

  ordered_record_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  orl_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("ordered_record_list: mismatch");
      $finish;
    end
  end

  task automatic issue(input orl_pkg::orl_req_t c);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 30) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= c;
    sent[c.command]++;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic send_command(logic [orl_pkg::CMD_W-1:0] cmd, logic [orl_pkg::POS_W-1:0] pos,
                              logic [orl_pkg::KEY_W-1:0] key, logic sex,
                              logic [orl_pkg::AGE_W-1:0] age,
                              logic [orl_pkg::CAT_W-1:0] cat);
    orl_pkg::orl_req_t c;
    c.command  = cmd;
    c.position = pos;
    c.key      = key;
    c.sex      = sex;
    c.age      = age;
    c.category = cat;
    issue(c);
  endtask

  initial begin
    int n;
    int pick;
    int ins_share;
    int del_share;
    logic [orl_pkg::CMD_W-1:0] cmd;
    logic [orl_pkg::POS_W-1:0] pos;
    logic [orl_pkg::KEY_W-1:0] key;
    logic [orl_pkg::CAT_W-1:0] cat;
    rst_ni = 1'b0;
    calm = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty list, bad positions, duplicates at front and tail, middle insert and delete
    send_command(orl_pkg::CmdFind,   5'd1,  32'h0000_0000, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdDelete, 5'd1,  32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdModify, 5'd1,  32'h0000_0000, 1'b1, 8'd255, 8'd255);
    send_command(orl_pkg::CmdCount,  5'd1,  32'h0000_0000, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdInsert, 5'd0,  32'h0000_0001, 1'b1, 8'd1,   8'd1);
    send_command(orl_pkg::CmdInsert, 5'd2,  32'h0000_0001, 1'b1, 8'd1,   8'd1);
    send_command(orl_pkg::CmdInsert, 5'd1,  32'h0000_0000, 1'b1, 8'd255, 8'd255);
    send_command(orl_pkg::CmdInsert, 5'd2,  32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdInsert, 5'd1,  32'h0000_0000, 1'b0, 8'd7,   8'd7);
    send_command(orl_pkg::CmdInsert, 5'd3,  32'hFFFF_FFFF, 1'b1, 8'd9,   8'd9);
    send_command(orl_pkg::CmdInsert, 5'd31, 32'h0000_0005, 1'b1, 8'd5,   8'd5);
    send_command(orl_pkg::CmdInsert, 5'd2,  32'h5A5A_5A5A, 1'b1, 8'd128, 8'd1);
    send_command(orl_pkg::CmdFind,   5'd0,  32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdModify, 5'd16, 32'h0000_0000, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdCount,  5'd1,  32'h0000_0000, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdCount,  5'd1,  32'h0000_0000, 1'b0, 8'd0,   8'd255);
    send_command(CmdUnusedLo, 5'd31, 32'hFFFF_FFFF, 1'b1, 8'd255, 8'd255);
    send_command(CmdUnusedHi, 5'd1,  32'h0000_0000, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdDelete, 5'd1,  32'h5A5A_5A5A, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdFind,   5'd1,  32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdDelete, 5'd1,  32'h0000_0000, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdDelete, 5'd1,  32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0);
    send_command(orl_pkg::CmdInsert, 5'd16, 32'hA5A5_A5A5, 1'b1, 8'd3,   8'd3);

    // alternating fill and drain phases over a small key pool so the list runs full
    for (n = 0; n < RANDOM_CMDS; n++) begin
      calm <= (n >= 1000 && n < 1300);
      ins_share = ((n / 250) % 2 == 1) ? 20 : 45;
      del_share = ((n / 250) % 2 == 1) ? 40 : 15;
      pick = $urandom_range(0, 99);
      if (pick < ins_share) begin
        cmd = orl_pkg::CmdInsert;
      end else if (pick < ins_share + del_share) begin
        cmd = orl_pkg::CmdDelete;
      end else if (pick < ins_share + del_share + 15) begin
        cmd = orl_pkg::CmdFind;
      end else if (pick < ins_share + del_share + 25) begin
        cmd = orl_pkg::CmdModify;
      end else if (pick < ins_share + del_share + 35) begin
        cmd = orl_pkg::CmdCount;
      end else begin
        cmd = orl_pkg::CMD_W'($urandom_range(CmdUnusedLo, CmdUnusedHi));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        pos = orl_pkg::POS_W'($urandom_range(1, 4));
      end else if (pick < 9) begin
        pos = orl_pkg::POS_W'($urandom_range(1, orl_pkg::DEPTH + 1));
      end else begin
        pos = orl_pkg::POS_W'($urandom_range(0, 31));
      end
      if ($urandom_range(0, 9) < 9) begin
        key = key_pool[5'($urandom_range(0, KEY_POOL - 1))];
      end else begin
        key = $urandom;
      end
      if ($urandom_range(0, 1) == 1) begin
        cat = orl_pkg::CAT_W'($urandom_range(0, 3));
      end else begin
        cat = orl_pkg::CAT_W'($urandom_range(0, 255));
      end
      send_command(cmd, pos, key, 1'($urandom_range(0, 1)),
                   orl_pkg::AGE_W'($urandom_range(0, 255)), cat);
    end
    req_if.valid <= 1'b0;
    calm <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d inserts, %0d deletes, %0d finds, %0d modifies, %0d counts,",
             sent[orl_pkg::CmdInsert], sent[orl_pkg::CmdDelete], sent[orl_pkg::CmdFind],
             sent[orl_pkg::CmdModify], sent[orl_pkg::CmdCount]);
    $display("%0d unused codes and %0d results checked against the predicted list contents",
             sent[CmdUnusedLo] + sent[CmdUnusedMid] + sent[CmdUnusedHi], checked);
    if (fail_count == 0 && pending == 0) begin
      $display("ordered_record_list: match");
    end else begin
      $display("ordered_record_list: mismatch");
    end
    $finish;
  end

endmodule
